// ===== hdl/membership_set_table_top_defines.svh =====
// Assertion macros shared by the membership set table RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef MEMBERSHIP_SET_TABLE_TOP_DEFINES_SVH
`define MEMBERSHIP_SET_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MST_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MST_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/mst_pkg.sv =====
// Package for the membership set table: codes, defaults and shared types.
// Depends on nothing; used by the interfaces, the slot cell and the top level.
package mst_pkg;

  localparam int MST_SLOTS    = 16;
  localparam int MST_KEY_BITS = 32;

  localparam int OP_W    = 2;
  localparam int REQ_KEY_W = 32;
  localparam int COUNT_W = 5;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE   = 2'd1;
  localparam logic [OP_W-1:0] OP_CONTAINS = 2'd2;

  // Control part of the search token that walks down the slot chain.
  typedef struct packed {
    logic            valid;
    logic [OP_W-1:0] op;
    logic            hit;   // an earlier slot held the key
    logic            free;  // an earlier slot was free
  } tok_ctl_t;

  // Write command broadcast to all slots at commit.
  typedef struct packed {
    logic set;
    logic clr;
  } wr_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT
  } state_t;

endpackage

// ===== hdl/mst_req_if.sv =====
// Request channel of the membership set table: valid/ready plus payload.
// Depends on mst_pkg for the field widths.
interface mst_req_if import mst_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [REQ_KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

// ===== hdl/mst_rsp_if.sv =====
// Response channel of the membership set table: valid/ready plus payload.
// Depends on mst_pkg for the field widths.
interface mst_rsp_if import mst_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               ok;
  logic               table_full;
  logic [COUNT_W-1:0] element_count;

  modport source (output valid, output ok, output table_full, output element_count,
                  input ready);
  modport sink   (input valid, input ok, input table_full, input element_count,
                  output ready);
endinterface

// ===== hdl/mst_cell.sv =====
// One slot of the membership set table: key, valid mark and a token stage.
// Depends on mst_pkg; instantiated in a row by membership_set_table_top.
module mst_cell import mst_pkg::*; #(
  parameter int IDX      = 0,
  parameter int SLOTS    = MST_SLOTS,
  parameter int KEY_BITS = MST_KEY_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  tok_ctl_t                   tok_in,
  input  logic [KEY_BITS-1:0]        tok_in_key,
  input  logic [$clog2(SLOTS)-1:0]   tok_in_hit_idx,
  input  logic [$clog2(SLOTS)-1:0]   tok_in_free_idx,
  output tok_ctl_t                   tok_out,
  output logic [KEY_BITS-1:0]        tok_out_key,
  output logic [$clog2(SLOTS)-1:0]   tok_out_hit_idx,
  output logic [$clog2(SLOTS)-1:0]   tok_out_free_idx,
  input  wr_cmd_t                    wr,
  input  logic [$clog2(SLOTS)-1:0]   wr_idx,
  input  logic [KEY_BITS-1:0]        wr_key
);

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [KEY_BITS-1:0] slot_key;
  logic                slot_valid;
  logic                match;
  logic                wr_here;

  assign match   = slot_valid && (slot_key == tok_in_key);
  assign wr_here = (wr_idx == MY_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
    end else if (wr_here && wr.set) begin
      slot_valid <= 1'b1;
    end else if (wr_here && wr.clr) begin
      slot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here && wr.set) begin
      slot_key <= wr_key;
    end
  end

  // The lowest matching and the lowest free slot win: later cells only fill
  // in what no earlier cell has claimed.
  always_ff @(posedge clk) begin
    tok_out.op       <= tok_in.op;
    tok_out.hit      <= tok_in.hit || match;
    tok_out.free     <= tok_in.free || !slot_valid;
    tok_out_key      <= tok_in_key;
    tok_out_hit_idx  <= (!tok_in.hit && match) ? MY_IDX : tok_in_hit_idx;
    tok_out_free_idx <= (!tok_in.free && !slot_valid) ? MY_IDX : tok_in_free_idx;
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

endmodule

// ===== hdl/membership_set_table_top.sv =====
// Top level of the membership set table: slot chain, sequencer, result register.
// Depends on mst_pkg, mst_req_if, mst_rsp_if, mst_cell and the assertion macros.
`include "membership_set_table_top_defines.svh"

// The membership set table holds up to SLOTS distinct keys of KEY_BITS bits.
// Each request beat carries an operation (insert, remove or contains) and a
// key, and produces exactly one response beat with ok, table_full and the
// element count after the operation. Key bits above KEY_BITS are ignored, and
// the unused operation code leaves the table alone and answers ok = 0.
// The slots form a row of cells. An accepted request becomes a search token
// that steps through one cell per cycle, picking up the lowest slot holding
// the key and the lowest free slot. When the token leaves the last cell the
// sequencer commits: it broadcasts one write to the chosen slot, updates the
// count and loads the response register. The response beat is offered
// once the token has walked the cell row, been captured in the pending
// register and been committed. The next request is accepted in the cycle
// after commit, so only one request is in the table at a time, even while the
// previous response still waits to be taken. Ready stays low during reset.
// The commit itself holds off only when an older response is still unread.
module membership_set_table_top import mst_pkg::*; #(
  parameter int SLOTS    = MST_SLOTS,
  parameter int KEY_BITS = MST_KEY_BITS
) (
  input  logic     clk,
  input  logic     rst,
  mst_req_if.sink  req,
  mst_rsp_if.source rsp
);

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int KEY_USE = (KEY_BITS < REQ_KEY_W) ? KEY_BITS : REQ_KEY_W;

  state_t state, state_next;

  // Token chain: entry s feeds cell s, entry SLOTS is the tail.
  tok_ctl_t            tok     [SLOTS+1];
  logic [KEY_BITS-1:0] tok_key [SLOTS+1];
  logic [IDX_W-1:0]    tok_hit [SLOTS+1];
  logic [IDX_W-1:0]    tok_free[SLOTS+1];

  // Token captured at the tail, waiting for commit.
  tok_ctl_t            pend;
  logic [KEY_BITS-1:0] pend_key;
  logic [IDX_W-1:0]    pend_hit_idx;
  logic [IDX_W-1:0]    pend_free_idx;

  logic [CNT_W-1:0]    count, count_next;
  wr_cmd_t             wr;
  logic [IDX_W-1:0]    wr_idx;
  logic                commit_go;
  logic                res_ok;
  logic                res_full;
  logic                req_beat;

  assign req.ready = (state == ST_IDLE) && !rst;
  assign req_beat  = req.valid && req.ready;

  // Inject the request at the head of the chain, key trimmed to KEY_BITS.
  assign tok[0].valid = req_beat;
  assign tok[0].op    = req.operation;
  assign tok[0].hit   = 1'b0;
  assign tok[0].free  = 1'b0;
  assign tok_key[0]   = KEY_BITS'(req.key[KEY_USE-1:0]);
  assign tok_hit[0]   = '0;
  assign tok_free[0]  = '0;

  for (genvar s = 0; s < SLOTS; s++) begin : g_cell
    mst_cell #(
      .IDX      (s),
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk              (clk),
      .rst              (rst),
      .tok_in           (tok[s]),
      .tok_in_key       (tok_key[s]),
      .tok_in_hit_idx   (tok_hit[s]),
      .tok_in_free_idx  (tok_free[s]),
      .tok_out          (tok[s+1]),
      .tok_out_key      (tok_key[s+1]),
      .tok_out_hit_idx  (tok_hit[s+1]),
      .tok_out_free_idx (tok_free[s+1]),
      .wr               (wr),
      .wr_idx           (wr_idx),
      .wr_key           (pend_key)
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: walk the chain, then commit once the response register is free.
  always_comb begin
    state_next = state;
    commit_go  = 1'b0;
    wr         = '0;
    wr_idx     = pend_free_idx;
    res_ok     = 1'b0;
    res_full   = 1'b0;
    count_next = count;
    case (state)
      ST_IDLE: begin
        if (req_beat) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (tok[SLOTS].valid) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (!rsp.valid || rsp.ready) begin
          commit_go  = 1'b1;
          state_next = ST_IDLE;
          case (pend.op)
            OP_INSERT: begin
              if (!pend.hit && pend.free) begin
                wr.set     = 1'b1;
                wr_idx     = pend_free_idx;
                res_ok     = 1'b1;
                count_next = count + CNT_W'(1);
              end else if (!pend.hit) begin
                res_full = 1'b1;
              end
            end
            OP_REMOVE: begin
              if (pend.hit) begin
                wr.clr     = 1'b1;
                wr_idx     = pend_hit_idx;
                res_ok     = 1'b1;
                count_next = count - CNT_W'(1);
              end
            end
            OP_CONTAINS: begin
              res_ok = pend.hit;
            end
            default: begin
              res_ok = 1'b0;
            end
          endcase
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && tok[SLOTS].valid) begin
      pend          <= tok[SLOTS];
      pend_key      <= tok_key[SLOTS];
      pend_hit_idx  <= tok_hit[SLOTS];
      pend_free_idx <= tok_free[SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Response register: holds its beat until taken, loads a new one at commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (commit_go) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit_go) begin
      rsp.ok            <= res_ok;
      rsp.table_full    <= res_full;
      rsp.element_count <= COUNT_W'(count_next);
    end
  end

  // A commit always leaves a response beat waiting.
  `MST_ASSERT_NXT(a_commit_rsp, clk, rst, commit_go, rsp.valid, "commit without response")
  // The count never runs past the number of slots.
  `MST_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= CNT_W'(SLOTS), "count overflow")
  // A successful insert raises the count by exactly one.
  `MST_ASSERT_NXT(a_ins_count, clk, rst, commit_go && wr.set,
                  count == $past(count) + CNT_W'(1), "insert count mismatch")
  // A token reaches the chain tail only while the sequencer is scanning.
  `MST_ASSERT_IMP(a_tail_scan, clk, rst, tok[SLOTS].valid, state == ST_SCAN,
                  "token at tail outside scan")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for membership_set_table_top, the fixed-slot key set.
// Depends on mst_pkg, mst_req_if, mst_rsp_if and the RTL of the table itself.
// Request beats come from named test tasks; response beats are checked against a local model.
module tb import mst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The request field is two bits wide, and code 3 is not an operation.
  // The table must ignore it and still answer with one response beat.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // The run is stopped here if it is still going. A clean run takes about
  // 640 beats plus one long receiver hold-off.
  localparam int CYCLE_LIMIT = 200000;

  // Quiet wait at the end of the run, scaled to the number of slots.
  localparam int TAIL_CYCLES = 4 * (MST_SLOTS + 2);

  // Length of the receiver hold-off in the back-pressure test.
  localparam int HOLD_CYCLES = 300;

  localparam int POOL_SIZE = 24;

  // One expected response beat.
  typedef struct packed {
    logic               ok;
    logic               table_full;
    logic [COUNT_W-1:0] element_count;
  } set_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mst_req_if req ();
  mst_rsp_if rsp ();

  membership_set_table_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always #5 clk = ~clk;

  // Local copy of the table. A key entry is only compared where its valid
  // mark is set, the same as in the block.
  logic [MST_KEY_BITS-1:0] model_key   [MST_SLOTS];
  logic                    model_valid [MST_SLOTS];
  int                      model_count;

  // Responses that are owed by the block, oldest first.
  set_rsp_t pending_rsp[$];

  // Keys for the random part. More keys than slots, so inserts fill
  // the table and also hit existing keys. Neighbors differ by one bit so
  // the key compare is tested near its edges.
  logic [31:0] key_pool [POOL_SIZE];

  int  mismatches = 0;
  int  cycles     = 0;
  bit  no_idle    = 1'b0;   // turns off random idling on both sides
  bit  hold_req   = 1'b0;   // asks the receiver to start its hold-off
  int  hold_left  = 0;

  // Apply one request to the local table and return the response it owes.
  function automatic set_rsp_t predict_set_op(logic [OP_W-1:0] op, logic [31:0] key);
    set_rsp_t r;
    int       hit;
    int       free_slot;
    hit       = -1;
    free_slot = -1;
    r         = '0;
    for (int i = 0; i < MST_SLOTS; i++) begin
      if (model_valid[i] && model_key[i] == key[MST_KEY_BITS-1:0] && hit < 0) hit = i;
      if (!model_valid[i] && free_slot < 0) free_slot = i;
    end
    case (op)
      OP_INSERT: begin
        // A duplicate insert fails without the full flag, even in a full table.
        if (hit < 0) begin
          if (free_slot >= 0) begin
            model_key[free_slot]   = key[MST_KEY_BITS-1:0];
            model_valid[free_slot] = 1'b1;
            model_count++;
            r.ok = 1'b1;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      OP_REMOVE: begin
        if (hit >= 0) begin
          model_valid[hit] = 1'b0;
          if (model_count > 0) model_count--;
          r.ok = 1'b1;
        end
      end
      OP_CONTAINS: begin
        r.ok = (hit >= 0);
      end
      default: begin
        // The unused code changes nothing and answers ok = 0.
      end
    endcase
    r.element_count = model_count[COUNT_W-1:0];
    return r;
  endfunction

  // Print one line for a mismatch and count it.
  task automatic report_mismatch(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  // Send one request beat. Random idle cycles come first unless idling is
  // off. On return the beat has been accepted and valid is still high, so a
  // following beat can go out on the next edge with no gap.
  task automatic send_req(logic [OP_W-1:0] op, logic [31:0] key);
    while (!no_idle && $urandom_range(99) < 18) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.key       <= key;
    do @(posedge clk); while (!req.ready);
    pending_rsp.push_back(predict_set_op(op, key));
  endtask

  // Drop valid and wait until every owed response beat has come back.
  task automatic wait_drain();
    req.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 85) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [OP_W-1:0] pick_op(int insert_pct, int remove_pct);
    int r;
    r = $urandom_range(99);
    if (r < insert_pct) return OP_INSERT;
    if (r < insert_pct + remove_pct) return OP_REMOVE;
    if (r < 95) return OP_CONTAINS;
    return OP_UNUSED;
  endfunction

  // Receiver side. Ready idles at random, or is held low for a long
  // stretch when the back-pressure test asks for it. Every response beat
  // is compared field by field with the oldest owed response.
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (pending_rsp.size() == 0) begin
          report_mismatch("unexpected response beat, owed count", 0, 0);
        end else begin
          set_rsp_t want;
          want = pending_rsp.pop_front();
          if (rsp.ok !== want.ok) report_mismatch("ok", rsp.ok, want.ok);
          if (rsp.table_full !== want.table_full)
            report_mismatch("table_full", rsp.table_full, want.table_full);
          if (rsp.element_count !== want.element_count)
            report_mismatch("element_count", rsp.element_count, want.element_count);
        end
      end
      if (hold_req) begin
        rsp.ready <= 1'b0;
        hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
        rsp.ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else begin
        rsp.ready <= no_idle || ($urandom_range(99) >= 18);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("membership_set_table_top verification failed");
      $finish;
    end
  end

  // The operations one by one on an empty table: both extreme keys, a
  // duplicate insert, a found and a missing query, the unused code, a
  // remove of an absent key, and removes that empty the table again.
  task automatic test_basic_ops();
    send_req(OP_INSERT, 32'h0000_0000);
    send_req(OP_INSERT, 32'hFFFF_FFFF);
    send_req(OP_INSERT, 32'hFFFF_FFFF);
    send_req(OP_CONTAINS, 32'h0000_0000);
    send_req(OP_CONTAINS, 32'h7FFF_FFFF);
    send_req(OP_UNUSED, 32'hFFFF_FFFF);
    send_req(OP_REMOVE, 32'h8000_0000);
    send_req(OP_REMOVE, 32'h0000_0000);
    send_req(OP_REMOVE, 32'hFFFF_FFFF);
    wait_drain();
  endtask

  // Fill every slot, then try an insert of a new key (full flag) and of a
  // held key (plain failure), the unused code at a count of 16, and a
  // remove in the middle so the next insert has to find the hole.
  task automatic test_fill_to_full();
    for (int i = 0; i < MST_SLOTS; i++) send_req(OP_INSERT, 32'h1111_1111 * i + 32'h5A);
    send_req(OP_INSERT, 32'hDEAD_BEEF);
    send_req(OP_INSERT, 32'h1111_1111 * 3 + 32'h5A);
    send_req(OP_UNUSED, 32'h0000_0000);
    send_req(OP_REMOVE, 32'h1111_1111 * 7 + 32'h5A);
    send_req(OP_INSERT, 32'hDEAD_BEEF);
    wait_drain();
  endtask

  // The receiver holds off for a long stretch while requests keep coming,
  // so the response register fills, the commit stalls and the block stops
  // taking requests. Everything must come out in order afterwards.
  task automatic test_backpressure();
    @(posedge clk);
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    for (int i = 0; i < 12; i++) send_req(pick_op(45, 30), pick_key());
    wait_drain();
  endtask

  // Random requests over the key pool with a given mix of operations.
  task automatic test_random_churn(int beats, int insert_pct, int remove_pct);
    for (int i = 0; i < beats; i++) send_req(pick_op(insert_pct, remove_pct), pick_key());
    wait_drain();
  endtask

  // Back-to-back requests and an always-ready receiver.
  task automatic test_steady_stream(int beats);
    no_idle <= 1'b1;
    for (int i = 0; i < beats; i++) send_req(pick_op(40, 35), pick_key());
    wait_drain();
    no_idle <= 1'b0;
  endtask

  initial begin
    req.valid     = 1'b0;
    req.operation = OP_INSERT;
    req.key       = '0;
    for (int i = 0; i < MST_SLOTS; i++) begin
      model_key[i]   = '0;
      model_valid[i] = 1'b0;
    end
    model_count = 0;

    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) begin
      if (i % 2 == 1) key_pool[i] = key_pool[i-1] ^ (32'h1 << $urandom_range(31));
      else key_pool[i] = $urandom;
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_ops();
    test_fill_to_full();
    test_backpressure();
    // Insert-heavy first so the table spends a long time full, then
    // remove-heavy so it drains to empty and refills.
    test_random_churn(250, 55, 20);
    test_random_churn(150, 20, 55);
    test_steady_stream(150);
    test_random_churn(50, 40, 35);

    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("membership_set_table_top verification clean");
    end else begin
      $display("membership_set_table_top verification failed");
    end
    $finish;
  end

endmodule
